FILE: rtl/scic_pkg.sv
// ============================================================================
// scic_pkg - shared definitions for the slave clock impulse controller
// Mode codes, field widths and the command/status bundles that run between
// the controller and the datapath.
// ============================================================================
package scic_pkg;

    // Width of the stored minute count; 1 to 6.
    localparam int COUNT_BITS = 6;

    // Width of the minute count fields on the ports.
    localparam int CNT_PORT_W = 6;

    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 16;

    localparam logic [1:0] MODE_RUNNING = 2'd0;
    localparam logic [1:0] MODE_STOPPED = 2'd1;
    localparam logic [1:0] MODE_ADDING  = 2'd2;
    localparam logic [1:0] MODE_WAITING = 2'd3;

    typedef logic [COUNT_BITS-1:0] t_cnt;

    // Controller to datapath.
    typedef struct packed {
        logic step;   // take the accepted beat and update the clock state
        logic emit;   // load the next result into the output register
    } t_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic out_free;   // output register can take a result this cycle
        logic emit_last;  // the next result to emit ends the run
    } t_stat;

endpackage

FILE: rtl/scic_ctrl.sv
// ============================================================================
// scic_ctrl - sequencer of the slave clock impulse controller
// Takes one input beat while idle, then, while the output register is free,
// issues one result a cycle until the last result of that beat is in it.
// ============================================================================
module scic_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    output scic_pkg::t_cmd  o_cmd,
    input  scic_pkg::t_stat i_stat
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EMIT = 1'b1;

    logic r_state;
    logic n_state;

    assign o_in_ready = (r_state == ST_IDLE);

    always_comb begin
        o_cmd.step = 1'b0;
        o_cmd.emit = 1'b0;
        n_state    = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.step = 1'b1;
                    n_state    = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_stat.emit_last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

FILE: rtl/scic_dp.sv
// ============================================================================
// scic_dp - datapath of the slave clock impulse controller
// Holds mode, minute count, last seen time and coil polarity, counts the
// pulses of a run and owns the output register.
// ============================================================================
module scic_dp (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  scic_pkg::t_cmd                   i_cmd,
    input  logic                             i_opcode,
    input  logic [scic_pkg::IN_DATA_W-1:0]   i_in_data,
    input  logic                             i_out_ready,
    output logic                             o_out_valid,
    output logic [scic_pkg::OUT_DATA_W-1:0]  o_out_data,
    output logic                             o_out_user,
    output logic                             o_out_last,
    output scic_pkg::t_stat                  o_stat
);

    // Unpacked input fields.
    logic       rtc_error;
    logic [5:0] second_now;
    logic [5:0] minute_now;
    logic [1:0] new_mode;
    logic       load_count;
    logic [5:0] new_count;

    assign rtc_error  = i_in_data[0];
    assign second_now = i_in_data[6:1];
    assign minute_now = i_in_data[12:7];
    assign new_mode   = i_in_data[14:13];
    assign load_count = i_in_data[15];
    assign new_count  = i_in_data[21:16];

    logic [1:0]     r_mode,        n_mode;
    scic_pkg::t_cnt r_count,       n_count;
    logic [5:0]     r_seen_second, n_seen_second;
    logic [5:0]     r_seen_minute, n_seen_minute;
    logic           r_polarity,    n_polarity;
    scic_pkg::t_cnt r_pulses_left, n_pulses_left;

    logic           r_out_valid;
    logic           r_out_pulse;
    logic           r_out_line;
    logic [1:0]     r_out_mode;
    scic_pkg::t_cnt r_out_count;
    logic           r_out_last;

    logic           pulse_due;
    logic           run_ends;

    assign pulse_due = (r_pulses_left != '0);
    assign run_ends  = (r_pulses_left <= scic_pkg::t_cnt'(1));

    assign o_stat.out_free  = !r_out_valid || i_out_ready;
    assign o_stat.emit_last = run_ends;

    always_comb begin
        n_mode        = r_mode;
        n_count       = r_count;
        n_seen_second = r_seen_second;
        n_seen_minute = r_seen_minute;
        n_polarity    = r_polarity;
        n_pulses_left = r_pulses_left;
        priority if (i_cmd.step) begin
            n_pulses_left = '0;
            if (i_opcode) begin
                n_mode = new_mode;
                if (load_count) begin
                    n_count = new_count[scic_pkg::COUNT_BITS-1:0];
                end
            end else if (!rtc_error && (second_now != r_seen_second)) begin
                n_seen_second = second_now;
                unique case (r_mode)
                    scic_pkg::MODE_RUNNING: begin
                        if (minute_now != r_seen_minute) begin
                            n_seen_minute = minute_now;
                            n_pulses_left = scic_pkg::t_cnt'(1);
                        end
                    end
                    scic_pkg::MODE_STOPPED: begin
                    end
                    scic_pkg::MODE_ADDING: begin
                        n_pulses_left = r_count;
                        n_mode        = scic_pkg::MODE_RUNNING;
                    end
                    scic_pkg::MODE_WAITING: begin
                        // An empty wait count releases the clock at once.
                        if (r_count == '0) begin
                            n_mode = scic_pkg::MODE_RUNNING;
                        end else if (minute_now != r_seen_minute) begin
                            n_seen_minute = minute_now;
                            n_count       = r_count - scic_pkg::t_cnt'(1);
                            if (r_count == scic_pkg::t_cnt'(1)) begin
                                n_mode = scic_pkg::MODE_RUNNING;
                            end
                        end
                    end
                endcase
            end
        end else if (i_cmd.emit && pulse_due) begin
            n_pulses_left = r_pulses_left - scic_pkg::t_cnt'(1);
            n_polarity    = ~r_polarity;
        end else begin
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= scic_pkg::MODE_RUNNING;
            r_count       <= '0;
            r_seen_second <= '0;
            r_seen_minute <= '0;
            r_polarity    <= 1'b0;
            r_pulses_left <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_mode        <= n_mode;
            r_count       <= n_count;
            r_seen_second <= n_seen_second;
            r_seen_minute <= n_seen_minute;
            r_polarity    <= n_polarity;
            r_pulses_left <= n_pulses_left;
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload; mode and count already stand as after the whole step.
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_pulse <= pulse_due;
            r_out_line  <= pulse_due & ~r_polarity;
            r_out_mode  <= r_mode;
            r_out_count <= r_count;
            r_out_last  <= run_ends;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_user  = r_out_pulse;
    assign o_out_last  = r_out_last;
    assign o_out_data  = {7'b0, scic_pkg::CNT_PORT_W'(r_out_count), r_out_mode, r_out_line};

endmodule

FILE: rtl/slave_clock_impulse_controller.sv
// ============================================================================
// slave_clock_impulse_controller - minute-impulse slave clock driver
// Turns clock samples and mode commands into coil drive pulses of
// alternating polarity, with running, stopped, adding and waiting modes.
// ============================================================================
//
//  Channel  | Direction | tdata (lowest bit up)                   | tuser       | tlast
//  ---------+-----------+-----------------------------------------+-------------+------------
//  s_axis   | in        | rtc_error, second_now, minute_now,      | opcode      | -
//           |           | new_mode, load_count, new_count, 2'b0   |             |
//  m_axis   | out       | pulse_line, mode_now, count_left, 7'b0  | pulse_valid | last_of_run
//
// An input beat is taken while the sequencer is idle. Its results then go
// into the output register one per cycle while the output side does not
// stall; a beat that drives k pulses gives k results and any other beat one
// result, and the pulse counter of the datapath counts the run.
// A stall on the output side holds the output register and stops the run;
// a finished result may wait there while the next input beat is taken.
// Reset is synchronous and active low and returns the clock to running mode
// with the next pulse on line B.
//
// The sequencer (scic_ctrl) decides when to take a beat and when to emit a
// result. The datapath (scic_dp) applies the mode rules, keeps the last seen
// second and minute, counts down the pulses of an adding run and flips the
// coil polarity after every pulse. Mode and count in each result reflect the
// state after the whole input beat has been applied.
// ============================================================================
module slave_clock_impulse_controller (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // rtc_error, second_now, minute_now, new_mode, load_count, new_count
    input  logic [scic_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // opcode
    input  logic [0:0]                       s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // pulse_line, mode_now, count_left
    output logic [scic_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    // pulse_valid
    output logic [0:0]                       m_axis_tuser,
    output logic                             m_axis_tlast
);

    scic_pkg::t_cmd  cmd;
    scic_pkg::t_stat stat;

    scic_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .o_cmd      (cmd),
        .i_stat     (stat)
    );

    scic_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_opcode    (s_axis_tuser[0]),
        .i_in_data   (s_axis_tdata),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata),
        .o_out_user  (m_axis_tuser[0]),
        .o_out_last  (m_axis_tlast),
        .o_stat      (stat)
    );

endmodule

FILE: rtl/scic_checker.sv
// ============================================================================
// scic_checker - port-level checks for the slave clock impulse controller
// Watches the top-level streams and flags broken result runs.
// ============================================================================
module scic_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             s_axis_tvalid,
    input logic                             s_axis_tready,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [scic_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    input logic [0:0]                       m_axis_tuser,
    input logic                             m_axis_tlast
);

    // A stalled result beat keeps its contents.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("result beat changed while stalled");

    // A status-only beat always ends its run and drives no coil line.
    a_status_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tlast && !m_axis_tdata[0])
        else $error("status beat without last flag or with a line set");

    // No new input is taken while a pulse run is still open.
    a_run_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
        else $error("input taken in the middle of a pulse run");

    // The cycle after an input beat is taken, the block is busy with it.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second input taken before the first was issued");

endmodule

bind slave_clock_impulse_controller scic_checker u_scic_checker (.*);
